// ----- rtl/mp2d_pkg.sv -----
// ----------------------------------------------------------------------------
// mp2d_pkg
// Shared types, widths and register codes of the 2-D max pooling block.
// ----------------------------------------------------------------------------
package mp2d_pkg;

  // Fixed field widths
  localparam int SAMPLE_BITS   = 16;
  localparam int COORD_BITS    = 10;
  localparam int CFG_IDX_BITS  = 4;
  localparam int CFG_DATA_BITS = 11;
  localparam int HEIGHT_CAP    = 1024;

  // Defaults for the top-level parameters
  localparam int MAX_WIDTH_DEF  = 1024;
  localparam int MAX_WINDOW_DEF = 4;

  // Register indexes
  localparam logic [CFG_IDX_BITS-1:0] CFG_WINDOW_SIZE  = 4'd0;
  localparam logic [CFG_IDX_BITS-1:0] CFG_STEP_STRIDE  = 4'd1;
  localparam logic [CFG_IDX_BITS-1:0] CFG_PLANE_WIDTH  = 4'd2;
  localparam logic [CFG_IDX_BITS-1:0] CFG_PLANE_HEIGHT = 4'd3;

  // Register reset values
  localparam logic [2:0]  RST_WINDOW_SIZE  = 3'd2;
  localparam logic [2:0]  RST_STEP_STRIDE  = 3'd2;
  localparam logic [10:0] RST_PLANE_WIDTH  = 11'd416;
  localparam logic [10:0] RST_PLANE_HEIGHT = 11'd416;

  // Channel words
  typedef struct packed {
    logic signed [SAMPLE_BITS-1:0] sample;
  } in_word_t;

  typedef struct packed {
    logic signed [SAMPLE_BITS-1:0] pooled_value;
    logic [COORD_BITS-1:0]         out_row;
    logic [COORD_BITS-1:0]         out_col;
    logic                          plane_done;
  } out_word_t;

  typedef struct packed {
    logic [CFG_IDX_BITS-1:0]  index;
    logic [CFG_DATA_BITS-1:0] value;
  } cfg_word_t;

  // Effective (clamped) geometry handed to the position tracker
  typedef struct packed {
    logic [2:0]  k;   // window side, 1..MAX_WINDOW
    logic [2:0]  s;   // stride, 1..7
    logic [10:0] w;   // plane width
    logic [10:0] h;   // plane height
  } geom_t;

  // Per-sample window flags and output coordinates
  typedef struct packed {
    logic                  emit;
    logic                  last;
    logic [COORD_BITS-1:0] orow;
    logic [COORD_BITS-1:0] ocol;
  } pos_t;

endpackage

// ----- rtl/mp2d_chan_if.sv -----
// ----------------------------------------------------------------------------
// mp2d_chan_if
// Valid/ready channel carrying one word of a configurable payload type.
// ----------------------------------------------------------------------------
interface mp2d_chan_if #(
  parameter type payload_t = logic
) ();
  logic     valid;
  logic     ready;
  payload_t data;

  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

// ----- rtl/max_pool_2d_top.sv -----
// ----------------------------------------------------------------------------
// max_pool_2d_top
// Streaming 2-D max pooling over one channel plane at a time.
// ----------------------------------------------------------------------------
// Usage:
//   in_i   : one sample word per handshake, raster order, planes back to back.
//   out_o  : one word per complete window: maximum, output row/column and a
//            plane_done flag on the plane's last window.
//   cfg_i  : register writes (window size, stride, width, height); always
//            ready. Any write to a known index restarts the plane at (0,0).
//            Write only while the block is idle.
// Throughput: one sample per clock while the skid register is empty; the
//   line-store RAMs, one per cell, are read and written once per sample.
// Pipeline: a window's bottom-right sample passes stage 1 (line-store read,
//   column maximum), stage 2 (window maximum) and the output register.
// Stall: an output register plus a one-word skid register decouple the
//   sides; in_i.ready drops only once the skid register holds a word, and
//   the whole pipeline then holds until the receiver takes a word.
// Reset: counters restart at (0,0) and registers take their defaults
//   (2, 2, 416, 416). Line store contents are not cleared; rows above the
//   first full window never reach a result.
// ----------------------------------------------------------------------------
module max_pool_2d_top #(
  parameter int MAX_WIDTH  = mp2d_pkg::MAX_WIDTH_DEF,
  parameter int MAX_WINDOW = mp2d_pkg::MAX_WINDOW_DEF
) (
  input  logic         clk_i,
  input  logic         rst_ni,
  mp2d_chan_if.sink    in_i,
  mp2d_chan_if.source  out_o,
  mp2d_chan_if.sink    cfg_i
);
  import mp2d_pkg::*;

  localparam int CB = $clog2(MAX_WIDTH);

  // --------------------------------------------------------------------------
  // Configuration registers
  // --------------------------------------------------------------------------
  logic [2:0]  win_size_q, stride_q;
  logic [10:0] width_q, height_q;
  logic        cfg_acc, restart;
  geom_t       geom;

  assign cfg_i.ready = 1'b1;
  assign cfg_acc     = cfg_i.valid && cfg_i.ready;

  always_comb begin
    restart = 1'b0;
    case (cfg_i.data.index)
      CFG_WINDOW_SIZE, CFG_STEP_STRIDE,
      CFG_PLANE_WIDTH, CFG_PLANE_HEIGHT: restart = cfg_acc;
      default:                           restart = 1'b0;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      win_size_q <= RST_WINDOW_SIZE;
      stride_q   <= RST_STEP_STRIDE;
      width_q    <= RST_PLANE_WIDTH;
      height_q   <= RST_PLANE_HEIGHT;
    end else if (cfg_acc) begin
      case (cfg_i.data.index)
        CFG_WINDOW_SIZE:  win_size_q <= cfg_i.data.value[2:0];
        CFG_STEP_STRIDE:  stride_q   <= cfg_i.data.value[2:0];
        CFG_PLANE_WIDTH:  width_q    <= cfg_i.data.value;
        CFG_PLANE_HEIGHT: height_q   <= cfg_i.data.value;
        default: ;
      endcase
    end
  end

  // Clamp to the usable range: zero counts as one, cap at the store limits
  always_comb begin
    if (win_size_q == 3'd0) begin
      geom.k = 3'd1;
    end else if (32'(win_size_q) > MAX_WINDOW) begin
      geom.k = 3'(MAX_WINDOW);
    end else begin
      geom.k = win_size_q;
    end
    geom.s = (stride_q == 3'd0) ? 3'd1 : stride_q;
    if (width_q == 11'd0) begin
      geom.w = 11'd1;
    end else if (32'(width_q) > MAX_WIDTH) begin
      geom.w = 11'(MAX_WIDTH);
    end else begin
      geom.w = width_q;
    end
    if (height_q == 11'd0) begin
      geom.h = 11'd1;
    end else if (32'(height_q) > HEIGHT_CAP) begin
      geom.h = 11'(HEIGHT_CAP);
    end else begin
      geom.h = height_q;
    end
  end

  // --------------------------------------------------------------------------
  // Flow control: the whole pipeline advances unless the skid word is held
  // --------------------------------------------------------------------------
  logic      adv, in_acc, out_take;
  logic      skid_vq, out_vq;
  out_word_t skid_q, out_q, res;

  assign adv        = !skid_vq;
  assign in_i.ready = adv;
  assign in_acc     = in_i.valid && in_i.ready;
  assign out_take   = out_vq && out_o.ready;

  // --------------------------------------------------------------------------
  // Position tracking
  // --------------------------------------------------------------------------
  logic [CB-1:0] pos_col;
  pos_t          pos;

  mp2d_pos_ctrl #(
    .MAX_WIDTH (MAX_WIDTH)
  ) u_pos (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .geom_i    (geom),
    .restart_i (restart),
    .adv_i     (in_acc),
    .col_o     (pos_col),
    .pos_o     (pos)
  );

  // --------------------------------------------------------------------------
  // Stage 1: line-store read data arrives; column maximum down the cells
  // --------------------------------------------------------------------------
  logic                          s1_vq;
  logic signed [SAMPLE_BITS-1:0] s1_sample_q;
  logic [CB-1:0]                 s1_col_q;
  pos_t                          s1_pos_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_vq <= 1'b0;
    end else if (adv) begin
      s1_vq <= in_acc;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_acc) begin
      s1_sample_q <= in_i.data.sample;
      s1_col_q    <= pos_col;
      s1_pos_q    <= pos;
    end
  end

  logic [SAMPLE_BITS-1:0]        chain_data [MAX_WINDOW];
  logic signed [SAMPLE_BITS-1:0] chain_max  [MAX_WINDOW];

  assign chain_data[0] = s1_sample_q;
  assign chain_max[0]  = s1_sample_q;

  // Cell j holds the row j+1 above the current one and shifts it one row down
  for (genvar j = 0; j < MAX_WINDOW - 1; j++) begin : g_cell
    mp2d_line_cell #(
      .DEPTH (MAX_WIDTH)
    ) u_cell (
      .clk_i     (clk_i),
      .rst_ni    (rst_ni),
      .rd_en_i   (in_acc),
      .rd_addr_i (pos_col),
      .wr_en_i   (adv && s1_vq),
      .wr_addr_i (s1_col_q),
      .wr_data_i (chain_data[j]),
      .use_i     (32'(geom.k) > (j + 1)),
      .max_i     (chain_max[j]),
      .rd_data_o (chain_data[j+1]),
      .max_o     (chain_max[j+1])
    );
  end

  // --------------------------------------------------------------------------
  // Stage 2: horizontal window of column maxima, reduced over k entries
  // --------------------------------------------------------------------------
  logic                          s2_vq;
  pos_t                          s2_pos_q;
  logic signed [SAMPLE_BITS-1:0] win_q [MAX_WINDOW];
  logic signed [SAMPLE_BITS-1:0] best;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s2_vq <= 1'b0;
    end else if (adv) begin
      s2_vq <= s1_vq;
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv && s1_vq) begin
      win_q[0] <= chain_max[MAX_WINDOW-1];
      for (int i = 1; i < MAX_WINDOW; i++) begin
        win_q[i] <= win_q[i-1];
      end
      s2_pos_q <= s1_pos_q;
    end
  end

  always_comb begin
    best = win_q[0];
    for (int i = 1; i < MAX_WINDOW; i++) begin
      if ((i < 32'(geom.k)) && (win_q[i] > best)) begin
        best = win_q[i];
      end
    end
  end

  assign res.pooled_value = best;
  assign res.out_row      = s2_pos_q.orow;
  assign res.out_col      = s2_pos_q.ocol;
  assign res.plane_done   = s2_pos_q.last;

  // --------------------------------------------------------------------------
  // Output register and skid register
  // --------------------------------------------------------------------------
  logic new_res;
  assign new_res = adv && s2_vq && s2_pos_q.emit;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_vq  <= 1'b0;
      skid_vq <= 1'b0;
    end else if (skid_vq) begin
      if (out_take) begin
        skid_vq <= 1'b0;
      end
    end else if (new_res) begin
      if (out_vq && !out_take) begin
        skid_vq <= 1'b1;
      end else begin
        out_vq <= 1'b1;
      end
    end else if (out_take) begin
      out_vq <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (skid_vq) begin
      if (out_take) begin
        out_q <= skid_q;
      end
    end else if (new_res) begin
      if (out_vq && !out_take) begin
        skid_q <= res;
      end else begin
        out_q <= res;
      end
    end
  end

  assign out_o.valid = out_vq;
  assign out_o.data  = out_q;

endmodule

// ----- rtl/mp2d_ram.sv -----
// ----------------------------------------------------------------------------
// mp2d_ram
// Simple dual-port RAM, one write and one registered read port, read-first.
// ----------------------------------------------------------------------------
module mp2d_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 1024
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

// ----- rtl/mp2d_line_cell.sv -----
// ----------------------------------------------------------------------------
// mp2d_line_cell
// One row of the line store: holds an earlier row, passes it one row down
// and folds it into the running column maximum.
// ----------------------------------------------------------------------------
module mp2d_line_cell #(
  parameter int DEPTH = mp2d_pkg::MAX_WIDTH_DEF
) (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic                                rd_en_i,
  input  logic [$clog2(DEPTH)-1:0]            rd_addr_i,
  input  logic                                wr_en_i,
  input  logic [$clog2(DEPTH)-1:0]            wr_addr_i,
  input  logic [mp2d_pkg::SAMPLE_BITS-1:0]    wr_data_i,
  input  logic                                use_i,
  input  logic signed [mp2d_pkg::SAMPLE_BITS-1:0] max_i,
  output logic [mp2d_pkg::SAMPLE_BITS-1:0]    rd_data_o,
  output logic signed [mp2d_pkg::SAMPLE_BITS-1:0] max_o
);
  import mp2d_pkg::*;

  logic [SAMPLE_BITS-1:0] ram_rd;
  logic                   fwd_q;
  logic [SAMPLE_BITS-1:0] fwd_data_q;

  mp2d_ram #(
    .WIDTH (SAMPLE_BITS),
    .DEPTH (DEPTH)
  ) u_ram (
    .clk_i   (clk_i),
    .we_i    (wr_en_i),
    .waddr_i (wr_addr_i),
    .wdata_i (wr_data_i),
    .re_i    (rd_en_i),
    .raddr_i (rd_addr_i),
    .rdata_o (ram_rd)
  );

  // Forward a write that lands on the address being read in the same cycle
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      fwd_q <= 1'b0;
    end else if (rd_en_i) begin
      fwd_q <= wr_en_i && (wr_addr_i == rd_addr_i);
    end
  end

  always_ff @(posedge clk_i) begin
    if (rd_en_i) begin
      fwd_data_q <= wr_data_i;
    end
  end

  assign rd_data_o = fwd_q ? fwd_data_q : ram_rd;

  always_comb begin
    max_o = max_i;
    if (use_i && ($signed(rd_data_o) > max_i)) begin
      max_o = $signed(rd_data_o);
    end
  end

endmodule

// ----- rtl/mp2d_pos_ctrl.sv -----
// ----------------------------------------------------------------------------
// mp2d_pos_ctrl
// Raster position tracker: column/row counters, stride phases and output
// coordinates of the window that ends at the current sample.
// ----------------------------------------------------------------------------
module mp2d_pos_ctrl #(
  parameter int MAX_WIDTH = mp2d_pkg::MAX_WIDTH_DEF
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  mp2d_pkg::geom_t               geom_i,
  input  logic                          restart_i,
  input  logic                          adv_i,
  output logic [$clog2(MAX_WIDTH)-1:0]  col_o,
  output mp2d_pkg::pos_t                pos_o
);
  import mp2d_pkg::*;

  localparam int CB = $clog2(MAX_WIDTH);
  localparam int XW = ((CB > 11) ? CB : 11) + 2;

  logic [CB-1:0]         col_q, col_d;
  logic [COORD_BITS-1:0] row_q, row_d;
  logic [2:0]            cph_q, cph_d, rph_q, rph_d;
  logic [COORD_BITS-1:0] ocol_q, ocol_d, orow_q, orow_d;

  logic [XW-1:0] col_x, row_x, km1_x, s_x, w_x, h_x, col_nx, row_nx;
  logic          col_wrap, row_wrap;
  logic [2:0]    sm1;

  assign col_x = XW'(col_q);
  assign row_x = XW'(row_q);
  assign km1_x = XW'(geom_i.k) - XW'(1);
  assign s_x   = XW'(geom_i.s);
  assign w_x   = XW'(geom_i.w);
  assign h_x   = XW'(geom_i.h);
  assign sm1   = geom_i.s - 3'd1;

  assign col_wrap = (col_x + XW'(1)) >= w_x;
  assign row_wrap = (row_x + XW'(1)) >= h_x;
  assign col_nx   = col_wrap ? '0 : col_x + XW'(1);
  assign row_nx   = row_wrap ? '0 : row_x + XW'(1);

  assign col_o      = col_q;
  assign pos_o.emit = (col_x >= km1_x) && (row_x >= km1_x) &&
                      (cph_q == 3'd0) && (rph_q == 3'd0);
  // Last window: no further window fits to the right nor below
  assign pos_o.last = ((col_x + s_x) >= w_x) && ((row_x + s_x) >= h_x);
  assign pos_o.orow = orow_q;
  assign pos_o.ocol = ocol_q;

  always_comb begin
    col_d  = col_q;
    row_d  = row_q;
    cph_d  = cph_q;
    rph_d  = rph_q;
    ocol_d = ocol_q;
    orow_d = orow_q;
    if (restart_i) begin
      col_d  = '0;
      row_d  = '0;
      cph_d  = '0;
      rph_d  = '0;
      ocol_d = '0;
      orow_d = '0;
    end else if (adv_i) begin
      col_d = CB'(col_nx);
      if (col_nx == km1_x) begin
        cph_d  = '0;
        ocol_d = '0;
      end else if (col_nx > km1_x) begin
        if (cph_q == sm1) begin
          cph_d  = '0;
          ocol_d = ocol_q + COORD_BITS'(1);
        end else begin
          cph_d = cph_q + 3'd1;
        end
      end
      if (col_wrap) begin
        row_d = COORD_BITS'(row_nx);
        if (row_nx == km1_x) begin
          rph_d  = '0;
          orow_d = '0;
        end else if (row_nx > km1_x) begin
          if (rph_q == sm1) begin
            rph_d  = '0;
            orow_d = orow_q + COORD_BITS'(1);
          end else begin
            rph_d = rph_q + 3'd1;
          end
        end
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      col_q  <= '0;
      row_q  <= '0;
      cph_q  <= '0;
      rph_q  <= '0;
      ocol_q <= '0;
      orow_q <= '0;
    end else begin
      col_q  <= col_d;
      row_q  <= row_d;
      cph_q  <= cph_d;
      rph_q  <= rph_d;
      ocol_q <= ocol_d;
      orow_q <= orow_d;
    end
  end

endmodule
